// ----- design/dpf_pkg.sv -----
// Shared types and codes for the packet FIFO with duplicate filter and range count.
package dpf_pkg;

	typedef enum logic [1:0] {
		REQ_ADD = 2'd0,
		REQ_FWD = 2'd1,
		REQ_CNT = 2'd2,
		REQ_NOP = 2'd3
	} req_t;

	typedef struct packed {
		logic [15:0] src;
		logic [15:0] dst;
		logic [31:0] ts;
	} record_t;

	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctl_t;

	localparam logic [6:0] LIMIT_RESET = 7'd64;
	localparam logic [6:0] COUNT_MAX   = 7'd127;

endpackage

// ----- design/dpf_cell.sv -----
// One record cell of the ring: holds, takes its neighbor's record, or loads a new one.
module dpf_cell (
	input  logic               clk,
	input  dpf_pkg::cell_ctl_t ctl,
	input  dpf_pkg::record_t   nb_rec,
	input  dpf_pkg::record_t   new_rec,
	output dpf_pkg::record_t   rec_q
);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rec_q <= new_rec;
		end else if (ctl.shift) begin
			rec_q <= nb_rec;
		end
	end

endmodule

// ----- design/dedup_packet_fifo_with_range_count_top.sv -----
// Top level: ring of record cells with request sequencer and result registers.
//
// Requests: drive req_type and the payload with start high; the transfer happens
// on a rising edge where start is high and busy is low. Each request gives one
// result, shown for exactly one cycle with done high; the receiver cannot stall.
// Records sit in a ring of DEPTH cells, oldest in cell 0. Add and count requests
// rotate the ring once around while the record passing cell 0 is compared, then
// store or report in the finish state: done rises on the same edge on which busy
// falls, and the next request may transfer once busy is low. Forward and no-op
// requests finish at once: done is high in the cycle right after the transfer
// and busy stays low, so they may be issued back to back.
// memory_limit is written through cfg_we / cfg_wdata, by the user only while idle;
// the block itself does not enforce this. 0 acts as 1, values above DEPTH act as DEPTH.
// Reset (arst_n low) empties the FIFO, sets the limit to 64 and drops any
// request in progress; cell contents are not cleared.
module dedup_packet_fifo_with_range_count_top #(
	parameter int DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [15:0] src_node,
	input  logic [15:0] dst_node,
	input  logic [31:0] pkt_time,
	input  logic [31:0] range_start,
	input  logic [31:0] range_end,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,
	output logic        done,
	output logic        add_accepted,
	output logic        fwd_valid,
	output logic [15:0] out_src,
	output logic [15:0] out_dst,
	output logic [31:0] out_time,
	output logic [6:0]  match_count
);

	localparam int IDXW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int OCCW = $clog2(DEPTH + 1);
	localparam int LW   = (OCCW > 7) ? OCCW : 7;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	state_t            state_q;
	logic [OCCW-1:0]   occ_q;
	logic [OCCW-1:0]   scan_q;
	logic [6:0]        limit_q;
	logic [6:0]        acc_q;
	logic              dup_q;
	dpf_pkg::req_t     req_q;
	dpf_pkg::record_t  new_q;
	logic [31:0]       lo_q;
	logic [31:0]       hi_q;

	dpf_pkg::record_t  rec [DEPTH];
	dpf_pkg::cell_ctl_t ctl [DEPTH];
	dpf_pkg::record_t  head;

	logic              take;
	logic              fwd_now;
	logic              scan_live;
	logic              is_dup;
	logic              is_match;
	logic [LW-1:0]     eff_lim;
	logic              full;
	logic              store;
	logic              shift_all;
	logic [IDXW-1:0]   wr_pos;

	assign head = rec[0];
	assign busy = (state_q != S_IDLE);
	assign take = start && (state_q == S_IDLE);
	assign fwd_now = take && (dpf_pkg::req_t'(req_type) == dpf_pkg::REQ_FWD) && (occ_q != '0);

	assign scan_live = (scan_q < occ_q);
	assign is_dup    = scan_live && (head == new_q);
	assign is_match  = scan_live && (head.dst == new_q.dst)
		&& (head.ts >= lo_q) && (head.ts <= hi_q);

	always_comb begin
		if (limit_q == '0) begin
			eff_lim = LW'(1);
		end else if (LW'(limit_q) > LW'(DEPTH)) begin
			eff_lim = LW'(DEPTH);
		end else begin
			eff_lim = LW'(limit_q);
		end
	end

	assign full  = (LW'(occ_q) >= eff_lim);
	assign store = (state_q == S_FINISH) && (req_q == dpf_pkg::REQ_ADD) && !dup_q;
	assign shift_all = (state_q == S_SCAN) || fwd_now || (store && full);
	assign wr_pos = full ? IDXW'(occ_q - OCCW'(1)) : IDXW'(occ_q);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		always_comb begin
			ctl[i].shift = shift_all;
			ctl[i].load  = store && (wr_pos == IDXW'(i));
		end

		dpf_cell u_cell (
			.clk     (clk),
			.ctl     (ctl[i]),
			.nb_rec  (rec[(i + 1) % DEPTH]),
			.new_rec (new_q),
			.rec_q   (rec[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			occ_q        <= '0;
			scan_q       <= '0;
			limit_q      <= dpf_pkg::LIMIT_RESET;
			acc_q        <= '0;
			dup_q        <= 1'b0;
			req_q        <= dpf_pkg::REQ_NOP;
			done         <= 1'b0;
			add_accepted <= 1'b0;
			fwd_valid    <= 1'b0;
			out_src      <= '0;
			out_dst      <= '0;
			out_time     <= '0;
			match_count  <= '0;
		end else begin
			done         <= 1'b0;
			add_accepted <= 1'b0;
			fwd_valid    <= 1'b0;
			out_src      <= '0;
			out_dst      <= '0;
			out_time     <= '0;
			match_count  <= '0;
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (take) begin
						req_q     <= dpf_pkg::req_t'(req_type);
						new_q.src <= src_node;
						new_q.dst <= dst_node;
						new_q.ts  <= pkt_time;
						lo_q      <= range_start;
						hi_q      <= range_end;
						scan_q    <= '0;
						acc_q     <= '0;
						dup_q     <= 1'b0;
						case (dpf_pkg::req_t'(req_type))
							dpf_pkg::REQ_ADD, dpf_pkg::REQ_CNT: begin
								state_q <= S_SCAN;
							end
							dpf_pkg::REQ_FWD: begin
								done <= 1'b1;
								if (occ_q != '0) begin
									fwd_valid <= 1'b1;
									out_src   <= head.src;
									out_dst   <= head.dst;
									out_time  <= head.ts;
									occ_q     <= occ_q - OCCW'(1);
								end
							end
							default: begin
								done <= 1'b1;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (is_dup) begin
						dup_q <= 1'b1;
					end
					if (is_match && (acc_q != dpf_pkg::COUNT_MAX)) begin
						acc_q <= acc_q + 7'd1;
					end
					scan_q <= scan_q + OCCW'(1);
					if (scan_q == OCCW'(DEPTH - 1)) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					done    <= 1'b1;
					state_q <= S_IDLE;
					if (req_q == dpf_pkg::REQ_ADD) begin
						add_accepted <= !dup_q;
						if (store && !full) begin
							occ_q <= occ_q + OCCW'(1);
						end
					end else begin
						match_count <= acc_q;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- design/dpf_checker.sv -----
// Port-level checks for the packet FIFO top level, bound to it.
module dpf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [1:0]  req_type,
	input logic        done,
	input logic        add_accepted,
	input logic        fwd_valid,
	input logic [15:0] out_src,
	input logic [15:0] out_dst,
	input logic [31:0] out_time,
	input logic [6:0]  match_count
);

	a_short_req_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req_type == dpf_pkg::REQ_FWD || req_type == dpf_pkg::REQ_NOP)
		|=> done && !busy)
		else $error("forward or no-op transfer did not finish in one cycle");

	a_long_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req_type == dpf_pkg::REQ_ADD || req_type == dpf_pkg::REQ_CNT)
		|=> busy && !done)
		else $error("add or count transfer did not hold busy");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(add_accepted && fwd_valid)
			&& !(add_accepted && (match_count != '0))
			&& !(fwd_valid && (match_count != '0)))
		else $error("result carries fields of more than one request kind");

	a_empty_fwd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!fwd_valid |-> (out_src == '0) && (out_dst == '0) && (out_time == '0))
		else $error("record fields nonzero without a forwarded record");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> !add_accepted && !fwd_valid && (match_count == '0))
		else $error("result fields active without done");

endmodule

bind dedup_packet_fifo_with_range_count_top dpf_checker u_dpf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.req_type     (req_type),
	.done         (done),
	.add_accepted (add_accepted),
	.fwd_valid    (fwd_valid),
	.out_src      (out_src),
	.out_dst      (out_dst),
	.out_time     (out_time),
	.match_count  (match_count)
);
